// ----- rtl/selective_repeat_window_control_top_assert.svh -----
// Assertion macros for the selective repeat window control block.
// Used by selective_repeat_window_control_top; relies on clk and rst_n there.
`ifndef SELECTIVE_REPEAT_WINDOW_CONTROL_TOP_ASSERT_SVH
`define SELECTIVE_REPEAT_WINDOW_CONTROL_TOP_ASSERT_SVH

// Checks that expr holds in the same cycle as cond.
`define SRWC_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Checks that expr holds in the cycle after cond.
`define SRWC_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ----- rtl/srwc_pkg.sv -----
// Shared constants and types of the selective repeat window control block.
// No dependencies; imported by selective_repeat_window_control_top.
`default_nettype none

package srwc_pkg;

    localparam int SEQ_BITS    = 4;
    localparam int SLOT_BITS   = SEQ_BITS - 1;
    localparam int WIN         = 2 ** SLOT_BITS;
    localparam int CNT_BITS    = SEQ_BITS;
    localparam int ACTION_BITS = 3;
    localparam int MODE_BITS   = 3;
    localparam int KIND_BITS   = 2;

    localparam logic [SEQ_BITS-1:0] SEQ_MAX = {SEQ_BITS{1'b1}};

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_NONE    = 3'd0,
        ACT_DATA    = 3'd1,
        ACT_ACK     = 3'd2,
        ACT_NAK     = 3'd3,
        ACT_RESTART = 3'd4,
        ACT_STORE   = 3'd5,
        ACT_DELIVER = 3'd6,
        ACT_RELEASE = 3'd7
    } action_t;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_PACKET   = 3'd0,
        MODE_PHYSICAL = 3'd1,
        MODE_FRAME    = 3'd2,
        MODE_DATA_TO  = 3'd3,
        MODE_ACK_TO   = 3'd4
    } mode_t;

    localparam logic [KIND_BITS-1:0] KIND_DATA = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_NAK  = 2'd2;

    typedef struct packed {
        action_t                action;
        logic [SEQ_BITS-1:0]    seq;
        logic [SEQ_BITS-1:0]    ack_value;
        logic [SLOT_BITS-1:0]   slot;
    } res_t;

    // True when b lies in [a, c) modulo the sequence space.
    function automatic logic in_window(input logic [SEQ_BITS-1:0] a,
                                       input logic [SEQ_BITS-1:0] b,
                                       input logic [SEQ_BITS-1:0] c);
        return ((a <= b) && (b < c)) || ((c < a) && (b < c)) || ((c < a) && (a <= b));
    endfunction

endpackage

`default_nettype wire

// ----- rtl/selective_repeat_window_control_top.sv -----
// Selective repeat window control: sequencer, window state and output stage.
// Depends on srwc_pkg and selective_repeat_window_control_top_assert.svh.
//
// Usage:
// The input stream carries one link event per transaction: s_axis_tuser holds
// the event mode, the frame good flag and the frame kind, s_axis_tdata holds
// the frame sequence number, the piggybacked ack and the timed-out sequence.
// Each event produces a run of command transactions on the output stream;
// m_axis_tuser holds the action and m_axis_tlast marks the last command of
// the run. An event that yields no command gives one status transaction.
// Commands are produced at most one per cycle, while the output can take
// them, by a small sequencer that steps through the window edges with one
// shared incrementer and one window comparator. s_axis_tready stays low from
// acceptance until the last command of the run has been placed in the output
// register, so the next event is taken only after the current one is done.
// Reset empties the send window, places the receive window at sequence zero,
// clears the received-slot bitmap and the outstanding count, allows a NAK and
// marks the link as not ready. When the receiver stalls, the output register
// holds its transaction and the sequencer waits with one further command
// buffered internally.
`default_nettype none
`include "selective_repeat_window_control_top_assert.svh"

module selective_repeat_window_control_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // frame_seq [3:0], rx_ack [7:4], timeout_seq [11:8], zero fill [15:12]
    input  wire logic [15:0]                       s_axis_tdata,
    // mode [2:0], frame_good [3], frame_kind [5:4]
    input  wire logic [5:0]                        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // seq [3:0], ack_value [7:4], slot [10:8], network_enable [11], zero fill [15:12]
    output logic [15:0]                            m_axis_tdata,
    // action [2:0]
    output logic [srwc_pkg::ACTION_BITS-1:0]       m_axis_tuser,
    output logic                                   m_axis_tlast
);

    import srwc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_STORE,
        ST_DELIVER,
        ST_RESEND,
        ST_RELEASE,
        ST_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [MODE_BITS-1:0]   mode_reg, mode_next;
    logic                   good_reg, good_next;
    logic [KIND_BITS-1:0]   kind_reg, kind_next;
    logic [SEQ_BITS-1:0]    fseq_reg, fseq_next;
    logic [SEQ_BITS-1:0]    fack_reg, fack_next;
    logic [SEQ_BITS-1:0]    tseq_reg, tseq_next;
    logic                   en_reg, en_next;
    logic                   moved_reg, moved_next;

    logic [SEQ_BITS-1:0]    send_lower_reg, send_lower_next;
    logic [SEQ_BITS-1:0]    send_next_reg, send_next_next;
    logic [SEQ_BITS-1:0]    recv_lower_reg, recv_lower_next;
    logic [SEQ_BITS-1:0]    recv_upper_reg, recv_upper_next;
    logic [CNT_BITS-1:0]    outstanding_reg, outstanding_next;
    logic [WIN-1:0]         arrived_reg, arrived_next;
    logic                   nak_allowed_reg, nak_allowed_next;
    logic                   link_ready_reg, link_ready_next;

    logic                   pend_valid_reg, pend_valid_next;
    res_t                   pend_reg, pend_next;
    logic                   out_valid_reg, out_valid_next;
    res_t                   out_reg, out_next;
    logic                   out_en_reg, out_en_next;
    logic                   out_last_reg, out_last_next;

    logic                   out_free;
    logic                   emit_ok;
    logic                   emit_req;
    res_t                   emit_res;
    logic [SEQ_BITS-1:0]    ack_now;
    logic [SEQ_BITS-1:0]    win_a, win_b, win_c;
    logic                   win_hit;
    logic [SEQ_BITS-1:0]    inc_in, inc_out;
    logic                   send_room;

    logic [MODE_BITS-1:0]   in_mode;
    logic                   in_good;
    logic [KIND_BITS-1:0]   in_kind;
    logic [SEQ_BITS-1:0]    in_fseq, in_fack;
    logic [SEQ_BITS:0]      rel_count;
    logic [CNT_BITS-1:0]    out_final;
    logic                   link_final;

    assign in_mode = s_axis_tuser[2:0];
    assign in_good = s_axis_tuser[3];
    assign in_kind = s_axis_tuser[5:4];
    assign in_fseq = s_axis_tdata[3:0];
    assign in_fack = s_axis_tdata[7:4];

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign emit_ok   = !pend_valid_reg || out_free;
    assign ack_now   = recv_lower_reg - SEQ_BITS'(1);
    assign send_room = (outstanding_reg < CNT_BITS'(WIN)) && link_ready_reg;
    assign inc_out   = inc_in + SEQ_BITS'(1);
    assign win_hit   = in_window(win_a, win_b, win_c);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.action;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {4'b0, out_en_reg, out_reg.slot, out_reg.ack_value, out_reg.seq};

    always_comb
    begin
        win_a  = send_lower_reg;
        win_b  = fack_reg;
        win_c  = send_next_reg;
        inc_in = send_lower_reg;
        case (state_reg)
            ST_DISPATCH:
            begin
                inc_in = send_next_reg;
            end
            ST_STORE:
            begin
                win_a = recv_lower_reg;
                win_b = fseq_reg;
                win_c = recv_upper_reg;
            end
            ST_DELIVER:
            begin
                inc_in = recv_lower_reg;
            end
            ST_RESEND:
            begin
                inc_in = fack_reg;
                win_b  = inc_out;
            end
            default:
            begin
                inc_in = send_lower_reg;
            end
        endcase
    end

    // Network enable after the whole event, worked out when the event is accepted.
    always_comb
    begin
        rel_count  = '0;
        link_final = link_ready_reg;
        out_final  = outstanding_reg;
        if (in_window(send_lower_reg, in_fack, send_next_reg))
        begin
            rel_count = {1'b0, in_fack - send_lower_reg} + (SEQ_BITS + 1)'(1);
        end
        case (in_mode)
            MODE_PACKET:
            begin
                if (send_room)
                begin
                    link_final = 1'b0;
                    out_final  = outstanding_reg + CNT_BITS'(1);
                end
            end
            MODE_PHYSICAL:
            begin
                link_final = 1'b1;
            end
            MODE_FRAME:
            begin
                if (!in_good)
                begin
                    if (nak_allowed_reg)
                    begin
                        link_final = 1'b0;
                    end
                end
                else
                begin
                    if (in_kind == KIND_DATA)
                    begin
                        if (in_fseq != recv_lower_reg && nak_allowed_reg)
                        begin
                            link_final = 1'b0;
                        end
                    end
                    else if (in_kind == KIND_NAK)
                    begin
                        if (in_window(send_lower_reg, in_fack + SEQ_BITS'(1), send_next_reg))
                        begin
                            link_final = 1'b0;
                        end
                    end
                    if ({1'b0, outstanding_reg} > rel_count)
                    begin
                        out_final = outstanding_reg - CNT_BITS'(rel_count);
                    end
                    else
                    begin
                        out_final = '0;
                    end
                end
            end
            MODE_DATA_TO, MODE_ACK_TO:
            begin
                link_final = 1'b0;
            end
            default:
            begin
                link_final = link_ready_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        good_next        = good_reg;
        kind_next        = kind_reg;
        fseq_next        = fseq_reg;
        fack_next        = fack_reg;
        tseq_next        = tseq_reg;
        en_next          = en_reg;
        moved_next       = moved_reg;
        send_lower_next  = send_lower_reg;
        send_next_next   = send_next_reg;
        recv_lower_next  = recv_lower_reg;
        recv_upper_next  = recv_upper_reg;
        outstanding_next = outstanding_reg;
        arrived_next     = arrived_reg;
        nak_allowed_next = nak_allowed_reg;
        link_ready_next  = link_ready_reg;
        pend_valid_next  = pend_valid_reg;
        pend_next        = pend_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_next         = out_reg;
        out_en_next      = out_en_reg;
        out_last_next    = out_last_reg;
        emit_req         = 1'b0;
        emit_res         = '{action: ACT_NONE, seq: '0, ack_value: '0, slot: '0};

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    mode_next  = in_mode;
                    good_next  = in_good;
                    kind_next  = in_kind;
                    fseq_next  = in_fseq;
                    fack_next  = in_fack;
                    tseq_next  = s_axis_tdata[11:8];
                    en_next    = (out_final < CNT_BITS'(WIN)) && link_final;
                    moved_next = 1'b0;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (mode_reg)
                    MODE_PACKET:
                    begin
                        if (send_room)
                        begin
                            emit_req = 1'b1;
                            emit_res = '{action: ACT_DATA, seq: send_next_reg,
                                         ack_value: ack_now,
                                         slot: send_next_reg[SLOT_BITS-1:0]};
                            if (emit_ok)
                            begin
                                outstanding_next = outstanding_reg + CNT_BITS'(1);
                                send_next_next   = inc_out;
                                link_ready_next  = 1'b0;
                                state_next       = ST_FINISH;
                            end
                        end
                        else
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                    MODE_PHYSICAL:
                    begin
                        link_ready_next = 1'b1;
                        state_next      = ST_FINISH;
                    end
                    MODE_FRAME:
                    begin
                        if (!good_reg)
                        begin
                            if (nak_allowed_reg)
                            begin
                                emit_req = 1'b1;
                                emit_res = '{action: ACT_NAK, seq: '0, ack_value: ack_now,
                                             slot: '0};
                                if (emit_ok)
                                begin
                                    nak_allowed_next = 1'b0;
                                    link_ready_next  = 1'b0;
                                    state_next       = ST_FINISH;
                                end
                            end
                            else
                            begin
                                state_next = ST_FINISH;
                            end
                        end
                        else if (kind_reg == KIND_DATA)
                        begin
                            emit_req = 1'b1;
                            if (fseq_reg != recv_lower_reg && nak_allowed_reg)
                            begin
                                emit_res = '{action: ACT_NAK, seq: '0, ack_value: ack_now,
                                             slot: '0};
                                if (emit_ok)
                                begin
                                    nak_allowed_next = 1'b0;
                                    link_ready_next  = 1'b0;
                                end
                            end
                            else
                            begin
                                emit_res = '{action: ACT_RESTART, seq: '0, ack_value: '0,
                                             slot: '0};
                            end
                            if (emit_ok)
                            begin
                                state_next = ST_STORE;
                            end
                        end
                        else if (kind_reg == KIND_NAK)
                        begin
                            state_next = ST_RESEND;
                        end
                        else
                        begin
                            state_next = ST_RELEASE;
                        end
                    end
                    MODE_DATA_TO:
                    begin
                        emit_req = 1'b1;
                        emit_res = '{action: ACT_DATA, seq: tseq_reg, ack_value: ack_now,
                                     slot: tseq_reg[SLOT_BITS-1:0]};
                        if (emit_ok)
                        begin
                            link_ready_next = 1'b0;
                            state_next      = ST_FINISH;
                        end
                    end
                    MODE_ACK_TO:
                    begin
                        emit_req = 1'b1;
                        emit_res = '{action: ACT_ACK, seq: '0, ack_value: ack_now, slot: '0};
                        if (emit_ok)
                        begin
                            link_ready_next = 1'b0;
                            state_next      = ST_FINISH;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_STORE:
            begin
                if (win_hit && !arrived_reg[fseq_reg[SLOT_BITS-1:0]])
                begin
                    emit_req = 1'b1;
                    emit_res = '{action: ACT_STORE, seq: fseq_reg, ack_value: '0,
                                 slot: fseq_reg[SLOT_BITS-1:0]};
                    if (emit_ok)
                    begin
                        arrived_next[fseq_reg[SLOT_BITS-1:0]] = 1'b1;
                        state_next = ST_DELIVER;
                    end
                end
                else
                begin
                    state_next = ST_RELEASE;
                end
            end
            ST_DELIVER:
            begin
                if (arrived_reg[recv_lower_reg[SLOT_BITS-1:0]])
                begin
                    emit_req = 1'b1;
                    emit_res = '{action: ACT_DELIVER, seq: recv_lower_reg, ack_value: '0,
                                 slot: recv_lower_reg[SLOT_BITS-1:0]};
                    if (emit_ok)
                    begin
                        arrived_next[recv_lower_reg[SLOT_BITS-1:0]] = 1'b0;
                        nak_allowed_next = 1'b1;
                        recv_lower_next  = inc_out;
                        recv_upper_next  = recv_upper_reg + SEQ_BITS'(1);
                        moved_next       = 1'b1;
                    end
                end
                else if (moved_reg)
                begin
                    emit_req = 1'b1;
                    emit_res = '{action: ACT_RESTART, seq: '0, ack_value: '0, slot: '0};
                    if (emit_ok)
                    begin
                        state_next = ST_RELEASE;
                    end
                end
                else
                begin
                    state_next = ST_RELEASE;
                end
            end
            ST_RESEND:
            begin
                if (win_hit)
                begin
                    emit_req = 1'b1;
                    emit_res = '{action: ACT_DATA, seq: inc_out, ack_value: ack_now,
                                 slot: inc_out[SLOT_BITS-1:0]};
                    if (emit_ok)
                    begin
                        link_ready_next = 1'b0;
                        state_next      = ST_RELEASE;
                    end
                end
                else
                begin
                    state_next = ST_RELEASE;
                end
            end
            ST_RELEASE:
            begin
                if (win_hit)
                begin
                    emit_req = 1'b1;
                    emit_res = '{action: ACT_RELEASE, seq: send_lower_reg, ack_value: '0,
                                 slot: send_lower_reg[SLOT_BITS-1:0]};
                    if (emit_ok)
                    begin
                        if (outstanding_reg != '0)
                        begin
                            outstanding_next = outstanding_reg - CNT_BITS'(1);
                        end
                        send_lower_next = inc_out;
                    end
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_en_next     = en_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    if (pend_valid_reg)
                    begin
                        out_next = pend_reg;
                    end
                    else
                    begin
                        out_next = '{action: ACT_NONE, seq: '0, ack_value: '0, slot: '0};
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A new command pushes the buffered one out; the last command waits
        // in the buffer until the run is known to be complete.
        if (emit_req && emit_ok)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
                out_en_next    = en_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_next       = emit_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            mode_reg        <= '0;
            good_reg        <= 1'b0;
            kind_reg        <= '0;
            fseq_reg        <= '0;
            fack_reg        <= '0;
            tseq_reg        <= '0;
            en_reg          <= 1'b0;
            send_lower_reg  <= '0;
            send_next_reg   <= '0;
            recv_lower_reg  <= '0;
            recv_upper_reg  <= SEQ_BITS'(WIN);
            outstanding_reg <= '0;
            arrived_reg     <= '0;
            nak_allowed_reg <= 1'b1;
            link_ready_reg  <= 1'b0;
            moved_reg       <= 1'b0;
            pend_valid_reg  <= 1'b0;
            pend_reg        <= '0;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
            out_en_reg      <= 1'b0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            good_reg        <= good_next;
            kind_reg        <= kind_next;
            fseq_reg        <= fseq_next;
            fack_reg        <= fack_next;
            tseq_reg        <= tseq_next;
            en_reg          <= en_next;
            send_lower_reg  <= send_lower_next;
            send_next_reg   <= send_next_next;
            recv_lower_reg  <= recv_lower_next;
            recv_upper_reg  <= recv_upper_next;
            outstanding_reg <= outstanding_next;
            arrived_reg     <= arrived_next;
            nak_allowed_reg <= nak_allowed_next;
            link_ready_reg  <= link_ready_next;
            moved_reg       <= moved_next;
            pend_valid_reg  <= pend_valid_next;
            pend_reg        <= pend_next;
            out_valid_reg   <= out_valid_next;
            out_reg         <= out_next;
            out_en_reg      <= out_en_next;
            out_last_reg    <= out_last_next;
        end
    end

    `SRWC_ASSERT_NOW(a_idle_no_pending, s_axis_tready, !pend_valid_reg,
        "A command is still buffered while a new transaction can be accepted.")
    `SRWC_ASSERT_NOW(a_outstanding_bound, 1'b1, outstanding_reg <= CNT_BITS'(WIN),
        "Outstanding count exceeds the window size.")
    `SRWC_ASSERT_NOW(a_recv_window_width, 1'b1,
        recv_upper_reg == recv_lower_reg + SEQ_BITS'(WIN),
        "Receive window edges are not one window apart.")
    `SRWC_ASSERT_NEXT(a_accept_starts_run, s_axis_tvalid && s_axis_tready,
        !s_axis_tready && !m_axis_tlast || !s_axis_tready,
        "Input accepted without the sequencer leaving idle.")

endmodule

`default_nettype wire

// ----- tb/tb_selective_repeat_window_control_top.sv -----
`timescale 1ns / 100ps
// Testbench for the selective repeat window control block: directed and random link events
// are checked against a window predictor, command by command. Depends on srwc_pkg and the top.

module tb_selective_repeat_window_control_top;

    import srwc_pkg::*;

    localparam int MAX_CMDS       = 20;
    localparam int RANDOM_EVENTS  = 380;
    localparam int HOLD_START     = 600;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 40;

    localparam logic [MODE_BITS-1:0] MODE_RESERVED = 3'd7;
    localparam logic [KIND_BITS-1:0] KIND_ACK      = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_OTHER    = 2'd3;

    typedef struct packed {
        logic [MODE_BITS-1:0] mode;
        logic                 good;
        logic [KIND_BITS-1:0] kind;
        logic [SEQ_BITS-1:0]  fseq;
        logic [SEQ_BITS-1:0]  fack;
        logic [SEQ_BITS-1:0]  tseq;
    } link_event_t;

    typedef struct packed {
        action_t               action;
        logic [SEQ_BITS-1:0]   seq;
        logic [SEQ_BITS-1:0]   ack_value;
        logic [SLOT_BITS-1:0]  slot;
        logic                  net_en;
        logic                  last;
    } cmd_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [5:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [ACTION_BITS-1:0] m_axis_tuser;
    logic        m_axis_tlast;

    link_event_t pending_events[$];
    link_event_t offered;
    cmd_t        expected_cmds[$];
    cmd_t        cmd_run[$];
    cmd_t        head_cmd;

    int events_queued;
    int events_taken;
    int mismatches;
    int send_idle_pct;
    int recv_idle_pct;
    int cycle_no;
    int hold_left;

    logic [SEQ_BITS-1:0] snd_base;
    logic [SEQ_BITS-1:0] snd_next;
    logic [SEQ_BITS-1:0] rcv_base;
    logic [SEQ_BITS-1:0] rcv_top;
    logic [SEQ_BITS-1:0] unacked;
    logic [WIN-1:0]      rcv_have;
    logic                nak_ok;
    logic                link_up;

    selective_repeat_window_control_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic seq_between(input logic [SEQ_BITS-1:0] lo,
                                         input logic [SEQ_BITS-1:0] probe,
                                         input logic [SEQ_BITS-1:0] hi);
        logic [SEQ_BITS-1:0] dist_probe;
        logic [SEQ_BITS-1:0] dist_hi;
        dist_probe = probe - lo;
        dist_hi    = hi - lo;
        return dist_probe < dist_hi;
    endfunction

    task automatic add_cmd(input action_t action, input logic [SEQ_BITS-1:0] seq,
                           input logic [SEQ_BITS-1:0] ack_value,
                           input logic [SLOT_BITS-1:0] slot);
        cmd_t c;
        c.action    = action;
        c.seq       = seq;
        c.ack_value = ack_value;
        c.slot      = slot;
        c.net_en    = 1'b0;
        c.last      = 1'b0;
        if (cmd_run.size() < MAX_CMDS)
            cmd_run.push_back(c);
    endtask

    task automatic tx_data(input logic [SEQ_BITS-1:0] seq);
        add_cmd(ACT_DATA, seq, rcv_base - 1'b1, seq[SLOT_BITS-1:0]);
        link_up = 1'b0;
    endtask

    task automatic send_ctl(input action_t action);
        add_cmd(action, '0, rcv_base - 1'b1, '0);
        link_up = 1'b0;
    endtask

    task automatic take_frame(input link_event_t ev);
        logic moved;
        if (!ev.good)
        begin
            if (nak_ok)
            begin
                send_ctl(ACT_NAK);
                nak_ok = 1'b0;
            end
            return;
        end
        if (ev.kind == KIND_DATA)
        begin
            if (ev.fseq != rcv_base && nak_ok)
            begin
                send_ctl(ACT_NAK);
                nak_ok = 1'b0;
            end
            else
                add_cmd(ACT_RESTART, '0, '0, '0);
            if (seq_between(rcv_base, ev.fseq, rcv_top) && !rcv_have[ev.fseq[SLOT_BITS-1:0]])
            begin
                moved = 1'b0;
                rcv_have[ev.fseq[SLOT_BITS-1:0]] = 1'b1;
                add_cmd(ACT_STORE, ev.fseq, '0, ev.fseq[SLOT_BITS-1:0]);
                while (rcv_have[rcv_base[SLOT_BITS-1:0]])
                begin
                    add_cmd(ACT_DELIVER, rcv_base, '0, rcv_base[SLOT_BITS-1:0]);
                    rcv_have[rcv_base[SLOT_BITS-1:0]] = 1'b0;
                    nak_ok   = 1'b1;
                    rcv_base = rcv_base + 1'b1;
                    rcv_top  = rcv_top + 1'b1;
                    moved    = 1'b1;
                end
                if (moved)
                    add_cmd(ACT_RESTART, '0, '0, '0);
            end
        end
        else if (ev.kind == KIND_NAK)
        begin
            if (seq_between(snd_base, ev.fack + 1'b1, snd_next))
                tx_data(ev.fack + 1'b1);
        end
        while (seq_between(snd_base, ev.fack, snd_next))
        begin
            add_cmd(ACT_RELEASE, snd_base, '0, snd_base[SLOT_BITS-1:0]);
            if (unacked != 0)
                unacked = unacked - 1'b1;
            snd_base = snd_base + 1'b1;
        end
    endtask

    task automatic step_windows(input link_event_t ev);
        logic en;
        cmd_t c;
        cmd_run.delete();
        case (ev.mode)
            MODE_PACKET:
                if (unacked < WIN && link_up)
                begin
                    unacked = unacked + 1'b1;
                    tx_data(snd_next);
                    snd_next = snd_next + 1'b1;
                end
            MODE_PHYSICAL: link_up = 1'b1;
            MODE_FRAME:    take_frame(ev);
            MODE_DATA_TO:  tx_data(ev.tseq);
            MODE_ACK_TO:   send_ctl(ACT_ACK);
            default:       ;
        endcase
        if (cmd_run.size() == 0)
            add_cmd(ACT_NONE, '0, '0, '0);
        en = (unacked < WIN) && link_up;
        foreach (cmd_run[i])
        begin
            c        = cmd_run[i];
            c.net_en = en;
            c.last   = (i == cmd_run.size() - 1);
            expected_cmds.push_back(c);
        end
    endtask

    function automatic link_event_t make_event(input logic [MODE_BITS-1:0] mode,
                                               input logic good,
                                               input logic [KIND_BITS-1:0] kind,
                                               input logic [SEQ_BITS-1:0] fseq,
                                               input logic [SEQ_BITS-1:0] fack,
                                               input logic [SEQ_BITS-1:0] tseq);
        link_event_t ev;
        ev.mode = mode;
        ev.good = good;
        ev.kind = kind;
        ev.fseq = fseq;
        ev.fack = fack;
        ev.tseq = tseq;
        return ev;
    endfunction

    function automatic link_event_t random_event();
        link_event_t         ev;
        int                  pick;
        logic [SEQ_BITS-1:0] in_flight;
        pick      = $urandom_range(0, 99);
        in_flight = snd_next - snd_base;
        ev.mode   = MODE_FRAME;
        ev.good   = 1'($urandom);
        ev.kind   = KIND_BITS'($urandom);
        ev.fseq   = SEQ_BITS'($urandom);
        ev.fack   = SEQ_BITS'($urandom);
        ev.tseq   = SEQ_BITS'($urandom);
        if ($urandom_range(0, 4) != 0)
            ev.fseq = SEQ_BITS'(rcv_base + $urandom_range(0, WIN - 1));
        if ($urandom_range(0, 3) != 0)
            ev.fack = SEQ_BITS'(snd_base + $urandom_range(0, in_flight) - 1);
        if (pick < 18)
            ev.mode = MODE_PHYSICAL;
        else if (pick < 40)
            ev.mode = MODE_PACKET;
        else if (pick < 62)
        begin
            ev.good = 1'b1;
            ev.kind = KIND_DATA;
        end
        else if (pick < 77)
        begin
            ev.good = 1'b1;
            ev.kind = KIND_ACK;
        end
        else if (pick < 82)
        begin
            ev.good = 1'b1;
            ev.kind = KIND_NAK;
        end
        else if (pick < 86)
            ev.good = 1'b0;
        else if (pick < 90)
        begin
            ev.mode = MODE_DATA_TO;
            if ($urandom_range(0, 3) != 0)
                ev.tseq = SEQ_BITS'(snd_base + $urandom_range(0, in_flight));
        end
        else if (pick < 94)
            ev.mode = MODE_ACK_TO;
        else if (pick < 97)
        begin
            ev.good = 1'b1;
            ev.kind = KIND_OTHER;
        end
        else
            ev.mode = MODE_BITS'(MODE_ACK_TO + $urandom_range(1, 3));
        return ev;
    endfunction

    task automatic push_event(input link_event_t ev);
        pending_events.push_back(ev);
        events_queued++;
        wait (events_taken == events_queued);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            snd_base      = '0;
            snd_next      = '0;
            rcv_base      = '0;
            rcv_top       = SEQ_BITS'(WIN);
            unacked       = '0;
            rcv_have      = '0;
            nak_ok        = 1'b1;
            link_up       = 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                step_windows(offered);
                events_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    offered = pending_events.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {4'b0000, offered.tseq, offered.fack, offered.fseq};
                    s_axis_tuser  <= {offered.kind, offered.good, offered.mode};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_no  <= 0;
            hold_left <= 0;
        end
        else
        begin
            cycle_no <= cycle_no + 1;
            if (cycle_no == HOLD_START)
                hold_left <= HOLD_CYCLES;
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_cmds.size() == 0)
            begin
                $error("command transaction with none expected: action %0d", m_axis_tuser);
                mismatches++;
            end
            else
            begin
                head_cmd = expected_cmds.pop_front();
                check_field("action", head_cmd.action, m_axis_tuser);
                check_field("seq", head_cmd.seq, m_axis_tdata[3:0]);
                check_field("ack_value", head_cmd.ack_value, m_axis_tdata[7:4]);
                check_field("slot", head_cmd.slot, m_axis_tdata[10:8]);
                check_field("network_enable", head_cmd.net_en, m_axis_tdata[11]);
                check_field("last", head_cmd.last, m_axis_tlast);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("[selective_repeat_window_control_top] ERROR");
        $finish;
    end

    initial
    begin
        link_event_t ev;
        int          sent;
        events_queued = 0;
        events_taken  = 0;
        mismatches    = 0;
        send_idle_pct = 26;
        recv_idle_pct = 51;
        rst_n         = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        push_event(make_event(MODE_PACKET, 1'b0, KIND_DATA, 4'd0, 4'd0, 4'd0));
        push_event(make_event(MODE_RESERVED, 1'b1, KIND_OTHER, 4'd15, 4'd15, 4'd15));
        push_event(make_event(MODE_ACK_TO + 1'b1, 1'b0, KIND_DATA, 4'd0, 4'd0, 4'd0));
        push_event(make_event(MODE_PHYSICAL, 1'b0, KIND_DATA, 4'd0, 4'd0, 4'd0));
        push_event(make_event(MODE_PACKET, 1'b0, KIND_DATA, 4'd0, 4'd0, 4'd0));
        push_event(make_event(MODE_DATA_TO, 1'b0, KIND_DATA, 4'd0, 4'd0, 4'd15));
        push_event(make_event(MODE_ACK_TO, 1'b0, KIND_DATA, 4'd0, 4'd0, 4'd0));
        push_event(make_event(MODE_FRAME, 1'b0, KIND_DATA, 4'd3, 4'd0, 4'd0));
        push_event(make_event(MODE_FRAME, 1'b0, KIND_NAK, 4'd3, 4'd0, 4'd0));
        push_event(make_event(MODE_FRAME, 1'b1, KIND_DATA, 4'd1, 4'd15, 4'd0));
        push_event(make_event(MODE_FRAME, 1'b1, KIND_DATA, 4'd0, 4'd0, 4'd0));
        push_event(make_event(MODE_PHYSICAL, 1'b0, KIND_DATA, 4'd0, 4'd0, 4'd0));
        push_event(make_event(MODE_PACKET, 1'b0, KIND_DATA, 4'd0, 4'd0, 4'd0));
        push_event(make_event(MODE_PHYSICAL, 1'b0, KIND_DATA, 4'd0, 4'd0, 4'd0));
        push_event(make_event(MODE_PACKET, 1'b0, KIND_DATA, 4'd0, 4'd0, 4'd0));
        push_event(make_event(MODE_FRAME, 1'b1, KIND_NAK, 4'd0, 4'd1, 4'd0));
        push_event(make_event(MODE_FRAME, 1'b1, KIND_OTHER, 4'd0, 4'd2, 4'd0));
        push_event(make_event(MODE_FRAME, 1'b1, KIND_DATA, 4'd15, 4'd0, 4'd0));
        push_event(make_event(MODE_FRAME, 1'b1, KIND_DATA, 4'd2, 4'd0, 4'd0));
        push_event(make_event(MODE_FRAME, 1'b1, KIND_ACK, 4'd0, 4'd9, 4'd0));

        sent = 0;
        while (sent < RANDOM_EVENTS)
        begin
            if (sent == RANDOM_EVENTS / 3)
            begin
                send_idle_pct = 51;
                recv_idle_pct = 26;
            end
            else if (sent == 2 * RANDOM_EVENTS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            ev = random_event();
            push_event(ev);
            sent++;
        end

        wait (expected_cmds.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[selective_repeat_window_control_top] OK");
        else
            $display("[selective_repeat_window_control_top] ERROR");
        $finish;
    end

endmodule
